>>> hdl/vec3_pkg.sv
// Shared opcode type and constants for the three-component vector ALU.
`timescale 1ns / 1ps

package vec3_pkg;

  // Operation codes; codes above OP_EQUAL produce an all-zero result
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MULT   = 4'd2,
    OP_SCALE  = 4'd3,
    OP_DOT    = 4'd4,
    OP_SQLEN  = 4'd5,
    OP_LEN    = 4'd6,
    OP_DIST   = 4'd7,
    OP_NORM   = 4'd8,
    OP_CROSS  = 4'd9,
    OP_EQUAL  = 4'd10
  } func_t;

  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  // Sum of squares accepted for a root is below 2^62, so the root has 31 bits
  localparam int RAD_W   = 62;
  localparam int SQ_BITS = 31;

endpackage

>>> hdl/vec3_vector_alu.sv
// Top level of the pipelined three-component fixed-point vector ALU.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid/in_ready carries func, vectors a and b and
//   scalar_in; a transfer happens when both are high on a rising clk edge.
//   Output channel out_valid/out_ready carries rx, ry, rz, scalar_out,
//   is_equal and saturated, one result per input item, in order.
//   Values are signed fixed point with FRAC_BITS fraction bits.
//   From input transfer to out_valid an item passes, in order: operand
//   select, multiply, sum and clamp, 31 square-root stages (one root bit
//   each), divider setup, FRAC_BITS + 1 divider stages (one quotient bit
//   each) and the output register.
//   Throughput is one item per cycle while the skid register is free;
//   every opcode takes the same path.
//   The output register is backed by a one-entry skid register, so
//   in_ready is a flop: when the receiver stalls, the pipeline keeps
//   running until the skid register fills, then the whole pipeline holds.
//   rst (synchronous, active high) drops all items in flight and clears
//   out_valid; in_ready is high in the cycle after reset.

module vec3_vector_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         func,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by_comp,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] scalar_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic signed [31:0] scalar_out,
  output logic               is_equal,
  output logic               saturated
);

  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 1;
  localparam int NW  = 32 + F;
  localparam int SQ  = vec3_pkg::SQ_BITS;
  localparam logic [30:0] NORM_EPS = 31'((64'd1 << F) / 64'd100000);

  typedef struct packed {
    vec3_pkg::func_t   func;
    logic [2:0][31:0]  a;
    logic [31:0]       s;
    logic [2:0][31:0]  r;
    logic              sat;
    logic              sq_ok;
    logic [5:0][31:0]  mx;
    logic [5:0][31:0]  my;
  } s1_t;

  typedef struct packed {
    vec3_pkg::func_t   func;
    logic [2:0][31:0]  a;
    logic [31:0]       s;
    logic [2:0][31:0]  r;
    logic              sat;
    logic              sq_ok;
    logic [5:0][63:0]  p;
  } s2_t;

  typedef struct packed {
    vec3_pkg::func_t                func;
    logic [2:0][31:0]               a;
    logic [2:0][31:0]               r;
    logic [31:0]                    sc;
    logic                           eq;
    logic                           sat;
    logic                           do_root;
    logic [vec3_pkg::RAD_W-1:0]     rem;
    logic [SQ-1:0]                  root;
  } sq_t;

  typedef struct packed {
    vec3_pkg::func_t    func;
    logic [2:0][31:0]   r;
    logic [31:0]        sc;
    logic               eq;
    logic               sat;
    logic               do_div;
    logic [2:0]         neg;
    logic [30:0]        dvs;
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] q;
  } dv_t;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             eq;
    logic             sat;
  } out_t;

  // Clamp a wide signed value to 32 bits
  function automatic logic ovf66(input logic signed [65:0] v);
    return v[65:31] != {35{v[65]}};
  endfunction

  function automatic logic [31:0] clamp66(input logic signed [65:0] v);
    logic [31:0] res;
    if (!ovf66(v)) begin
      res = v[31:0];
    end else if (v[65]) begin
      res = vec3_pkg::INT32_MIN;
    end else begin
      res = vec3_pkg::INT32_MAX;
    end
    return res;
  endfunction

  logic en;
  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  logic signed [32:0] dv [3];
  logic signed [32:0] sv [3];
  logic [2:0]         d_fit;
  logic [2:0]         a_fit;

  s1_t s1, s1_next;
  logic s1_v;
  s2_t s2, s2_next;
  logic s2_v;
  logic signed [65:0] pe [6];
  logic signed [65:0] sum3;
  logic signed [65:0] cr [3];
  logic [63:0]        sq_u;
  sq_t  s3_next;
  sq_t  sq_q [0:SQ];
  logic sq_v [0:SQ];
  dv_t  dv0;
  dv_t  dv_q [0:QW];
  logic dv_v [0:QW];
  out_t fin;
  out_t o, k;
  logic o_v, k_v;

  // Pipeline moves whenever the skid register is free
  assign en       = !k_v;
  assign in_ready = en;

  assign av[0] = ax;
  assign av[1] = ay;
  assign av[2] = az;
  assign bv[0] = bx;
  assign bv[1] = by_comp;
  assign bv[2] = bz;

  // Differences, sums and range flags for the squared terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i]    = {av[i][31], av[i]} - {bv[i][31], bv[i]};
      sv[i]    = {av[i][31], av[i]} + {bv[i][31], bv[i]};
      d_fit[i] = (dv[i][32] == dv[i][31]) && (dv[i] != 33'h1_8000_0000);
      a_fit[i] = (av[i] != vec3_pkg::INT32_MIN);
    end
  end

  // Stage 1: add/sub results and multiplier operand select
  always_comb begin
    s1_next      = '0;
    s1_next.func = vec3_pkg::func_t'(func);
    s1_next.a    = {az, ay, ax};
    s1_next.s    = scalar_in;
    unique case (vec3_pkg::func_t'(func)) inside
      vec3_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          s1_next.r[i] = clamp66({{33{sv[i][32]}}, sv[i]});
          s1_next.sat  = s1_next.sat | ovf66({{33{sv[i][32]}}, sv[i]});
        end
      end
      vec3_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          s1_next.r[i] = clamp66({{33{dv[i][32]}}, dv[i]});
          s1_next.sat  = s1_next.sat | ovf66({{33{dv[i][32]}}, dv[i]});
        end
      end
      vec3_pkg::OP_MULT, vec3_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          s1_next.mx[i] = av[i];
          s1_next.my[i] = bv[i];
        end
      end
      vec3_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          s1_next.mx[i] = av[i];
          s1_next.my[i] = scalar_in;
        end
      end
      vec3_pkg::OP_SQLEN, vec3_pkg::OP_LEN, vec3_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          s1_next.mx[i] = av[i];
          s1_next.my[i] = av[i];
        end
        s1_next.sq_ok = &a_fit;
      end
      vec3_pkg::OP_DIST, vec3_pkg::OP_EQUAL: begin
        for (int i = 0; i < 3; i++) begin
          s1_next.mx[i] = dv[i][31:0];
          s1_next.my[i] = dv[i][31:0];
        end
        s1_next.sq_ok = &d_fit;
      end
      vec3_pkg::OP_CROSS: begin
        s1_next.mx[0] = ay;  s1_next.my[0] = bz;
        s1_next.mx[1] = az;  s1_next.my[1] = by_comp;
        s1_next.mx[2] = az;  s1_next.my[2] = bx;
        s1_next.mx[3] = ax;  s1_next.my[3] = bz;
        s1_next.mx[4] = ax;  s1_next.my[4] = by_comp;
        s1_next.mx[5] = ay;  s1_next.my[5] = bx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: six signed 32x32 products
  always_comb begin
    s2_next.func  = s1.func;
    s2_next.a     = s1.a;
    s2_next.s     = s1.s;
    s2_next.r     = s1.r;
    s2_next.sat   = s1.sat;
    s2_next.sq_ok = s1.sq_ok;
    for (int i = 0; i < 6; i++) begin
      s2_next.p[i] = $signed(s1.mx[i]) * $signed(s1.my[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

  // Stage 3: sums of products, shift, clamp, root setup and equality test
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pe[i] = {{2{s2.p[i][63]}}, s2.p[i]};
    end
    sum3 = pe[0] + pe[1] + pe[2];
    for (int j = 0; j < 3; j++) begin
      cr[j] = pe[2*j] - pe[2*j+1];
    end
    sq_u = s2.p[0] + s2.p[1] + s2.p[2];

    s3_next      = '0;
    s3_next.func = s2.func;
    s3_next.a    = s2.a;
    s3_next.r    = s2.r;
    s3_next.sat  = s2.sat;
    unique case (s2.func) inside
      vec3_pkg::OP_MULT, vec3_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          s3_next.r[i] = clamp66(pe[i] >>> F);
          s3_next.sat  = s3_next.sat | ovf66(pe[i] >>> F);
        end
      end
      vec3_pkg::OP_DOT, vec3_pkg::OP_SQLEN: begin
        s3_next.sc  = clamp66(sum3 >>> F);
        s3_next.sat = ovf66(sum3 >>> F);
      end
      vec3_pkg::OP_CROSS: begin
        for (int j = 0; j < 3; j++) begin
          s3_next.r[j] = clamp66(cr[j] >>> F);
          s3_next.sat  = s3_next.sat | ovf66(cr[j] >>> F);
        end
      end
      vec3_pkg::OP_LEN, vec3_pkg::OP_DIST, vec3_pkg::OP_NORM: begin
        if (!s2.sq_ok || (sq_u >= (64'd1 << vec3_pkg::RAD_W))) begin
          s3_next.sc  = vec3_pkg::INT32_MAX;
          s3_next.sat = 1'b1;
        end else begin
          s3_next.do_root = 1'b1;
          s3_next.rem     = sq_u[vec3_pkg::RAD_W-1:0];
        end
      end
      vec3_pkg::OP_EQUAL: begin
        s3_next.eq = !s2.s[31] && (s2.s != 32'd0) && s2.sq_ok &&
                     (sq_u < ({32'd0, s2.s} << F));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_q[0] <= s3_next;
    end
  end

  // Square root: one root bit per stage, most significant first
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int KB = SQ - 1 - j;
    logic [63:0] trial;
    sq_t         nxt;

    always_comb begin
      nxt   = sq_q[j];
      trial = ({33'd0, sq_q[j].root} << (KB + 1)) + (64'd1 << (2 * KB));
      if ({2'b00, sq_q[j].rem} >= trial) begin
        nxt.rem      = sq_q[j].rem - trial[vec3_pkg::RAD_W-1:0];
        nxt.root[KB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_q[j+1] <= nxt;
      end
    end
  end

  // Divider setup: final length, normalize magnitudes and signs
  always_comb begin
    logic [31:0] mag;
    mag      = '0;
    dv0      = '0;
    dv0.func = sq_q[SQ].func;
    dv0.r    = sq_q[SQ].r;
    dv0.eq   = sq_q[SQ].eq;
    dv0.sat  = sq_q[SQ].sat;
    dv0.sc   = sq_q[SQ].do_root ? {1'b0, sq_q[SQ].root} : sq_q[SQ].sc;
    if (sq_q[SQ].func == vec3_pkg::OP_NORM) begin
      dv0.do_div = (dv0.sc[30:0] > NORM_EPS);
      dv0.dvs    = dv0.sc[30:0];
      for (int i = 0; i < 3; i++) begin
        dv0.r[i]   = sq_q[SQ].a[i];
        dv0.neg[i] = sq_q[SQ].a[i][31];
        mag        = sq_q[SQ].a[i][31] ? (~sq_q[SQ].a[i] + 32'd1) : sq_q[SQ].a[i];
        dv0.rem[i] = {mag, {F{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_q[0] <= dv0;
    end
  end

  // Restoring division: one quotient bit per stage in all three lanes
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int QB = QW - 1 - j;
    logic [NW:0] trial [3];
    dv_t         nxt;

    always_comb begin
      nxt = dv_q[j];
      for (int i = 0; i < 3; i++) begin
        trial[i] = {1'b0, dv_q[j].rem[i]} - ((NW + 1)'(dv_q[j].dvs) << QB);
        if (!trial[i][NW]) begin
          nxt.rem[i]    = trial[i][NW-1:0];
          nxt.q[i][QB]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[j+1] <= nxt;
      end
    end
  end

  // Apply signs to the normalized components
  always_comb begin
    logic [31:0] qe;
    fin.sc  = dv_q[QW].sc;
    fin.eq  = dv_q[QW].eq;
    fin.sat = dv_q[QW].sat;
    for (int i = 0; i < 3; i++) begin
      qe       = 32'(dv_q[QW].q[i]);
      fin.r[i] = dv_q[QW].r[i];
      if (dv_q[QW].do_div) begin
        fin.r[i] = dv_q[QW].neg[i] ? (~qe + 32'd1) : qe;
      end
    end
  end

  // Output register with skid: hold on stall, drain skid first
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      k_v <= 1'b0;
    end else if (k_v) begin
      if (out_ready) begin
        k_v <= 1'b0;
      end
    end else if (dv_v[QW]) begin
      if (!o_v || out_ready) begin
        o_v <= 1'b1;
      end else begin
        k_v <= 1'b1;
      end
    end else if (out_ready) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (k_v) begin
      if (out_ready) begin
        o <= k;
      end
    end else if (dv_v[QW]) begin
      if (!o_v || out_ready) begin
        o <= fin;
      end else begin
        k <= fin;
      end
    end
  end

  assign out_valid  = o_v;
  assign rx         = o.r[0];
  assign ry         = o.r[1];
  assign rz         = o.r[2];
  assign scalar_out = o.sc;
  assign is_equal   = o.eq;
  assign saturated  = o.sat;

  // A filled skid register always sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    k_v |-> o_v)
    else $error("skid register full while output register empty");

  // A stalled pipeline keeps its tail item
  a_tail_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_v[QW]) && $stable(dv_q[QW]))
    else $error("pipeline tail changed during stall");

  // Only the equality op can report a match
  a_eq_only_equal: assert property (@(posedge clk) disable iff (rst)
    (dv_v[QW] && (dv_q[QW].func != vec3_pkg::OP_EQUAL)) |-> !dv_q[QW].eq)
    else $error("is_equal set for a non-equality op");

  // A normalized component never exceeds one
  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    (dv_v[QW] && dv_q[QW].do_div) |->
      ((dv_q[QW].q[0] <= (QW'(1) << F)) && (dv_q[QW].q[1] <= (QW'(1) << F)) &&
       (dv_q[QW].q[2] <= (QW'(1) << F))))
    else $error("normalize quotient out of range");

endmodule
